/* src/wdcc_pkg.sv */
// Shared types, widths and register indexes for the window distinct color counter.
`default_nettype none
package wdcc_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int COORD_W   = 12;
   localparam int BOUND_W   = 13;
   localparam int COLOR_W   = 32;
   localparam int LIMIT_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] REG_X_START        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_START        = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_X_END          = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_Y_END          = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COMPARE_ENABLE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_LIMIT    = 3'd5;

   typedef struct packed {
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] y_start;
      logic [BOUND_W-1:0] x_end;
      logic [BOUND_W-1:0] y_end;
      logic               compare_enable;
      logic [LIMIT_W-1:0] color_limit;
   } cfg_type;

   typedef struct packed {
      logic               in_rect;
      logic               last;
      logic [COLOR_W-1:0] color;
   } pix_type;

   typedef struct packed {
      logic               few_colors;
      logic               overflow;
      logic [COUNT_W-1:0] distinct_count;
   } res_type;

endpackage
`default_nettype wire

/* src/window_distinct_color_counter.sv */
// Top level of the window distinct color counter.
// Counts the distinct 32-bit colors among pixels inside the half-open rectangle
// [x_start, x_end) x [y_start, y_end) and reports one result per frame on the
// pixel marked by req_tlast. The block takes one pixel per clock; a last pixel
// waits in the input register while a result is unaccepted, and its result is
// then registered. The rate is set by the combinational parallel compare
// of the color against all CAPACITY entries, which writes a new one in the same
// cycle. The store needs no clearing pass: a fill count marks live entries.
`default_nettype none
module window_distinct_color_counter #(
   parameter int CAPACITY = wdcc_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: pixel_x [11:0], pixel_y [23:12], color [55:24]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [wdcc_pkg::REQ_W-1:0]       req_tdata,
   input  wire logic                             req_tlast,
   // rsp_tdata: distinct_count [6:0], overflow [7], few_colors [8], zero [15:9]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [wdcc_pkg::RSP_W-1:0]            rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [wdcc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [wdcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RES_W = $bits(wdcc_pkg::res_type);

   wdcc_pkg::cfg_type cfg;
   wdcc_pkg::pix_type pix;
   wdcc_pkg::res_type res;
   logic              pix_valid;
   logic              out_free;
   logic              take;
   logic              rsp_valid_ff, rsp_valid_in;
   wdcc_pkg::res_type rsp_data_ff;

   // A pixel without the last mark never waits on the result side.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = pix_valid && (!pix.last || out_free);

   wdcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wdcc_window u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   wdcc_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .take  (take),
      .pix   (pix),
      .res   (res)
   );

   assign rsp_valid_in = (take && pix.last) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pix.last) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wdcc_pkg::RSP_W - RES_W){1'b0}}, rsp_data_ff};

endmodule
`default_nettype wire

/* src/wdcc_csr.sv */
// Configuration registers written through the plain write port.
`default_nettype none
module wdcc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [wdcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [wdcc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output wdcc_pkg::cfg_type                      cfg
);

   wdcc_pkg::cfg_type cfg_ff;
   wdcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            wdcc_pkg::REG_X_START:        cfg_in.x_start = csr_wdata[wdcc_pkg::COORD_W-1:0];
            wdcc_pkg::REG_Y_START:        cfg_in.y_start = csr_wdata[wdcc_pkg::COORD_W-1:0];
            wdcc_pkg::REG_X_END:          cfg_in.x_end   = csr_wdata[wdcc_pkg::BOUND_W-1:0];
            wdcc_pkg::REG_Y_END:          cfg_in.y_end   = csr_wdata[wdcc_pkg::BOUND_W-1:0];
            wdcc_pkg::REG_COMPARE_ENABLE: cfg_in.compare_enable = csr_wdata[0];
            wdcc_pkg::REG_COLOR_LIMIT:
               cfg_in.color_limit = csr_wdata[wdcc_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/wdcc_window.sv */
// Input register with the rectangle test applied on the way in.
`default_nettype none
module wdcc_window (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire wdcc_pkg::cfg_type              cfg,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [wdcc_pkg::REQ_W-1:0]     req_tdata,
   input  wire logic                           req_tlast,
   input  wire logic                           take,
   output logic                                pix_valid,
   output wdcc_pkg::pix_type                   pix
);

   logic                         valid_ff, valid_in;
   wdcc_pkg::pix_type            pix_ff, pix_in;
   logic [wdcc_pkg::COORD_W-1:0] px, py;
   logic                         load;

   assign px = req_tdata[wdcc_pkg::COORD_W-1:0];
   assign py = req_tdata[2*wdcc_pkg::COORD_W-1:wdcc_pkg::COORD_W];

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      pix_in.in_rect = (px >= cfg.x_start) && ({1'b0, px} < cfg.x_end) &&
                       (py >= cfg.y_start) && ({1'b0, py} < cfg.y_end);
      pix_in.last   = req_tlast;
      pix_in.color  = req_tdata[2*wdcc_pkg::COORD_W+wdcc_pkg::COLOR_W-1:2*wdcc_pkg::COORD_W];
      valid_in      = load || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

endmodule
`default_nettype wire

/* src/wdcc_store.sv */
// Color CAM with fill count and overflow flag; forms the frame result.
`default_nettype none
module wdcc_store #(
   parameter int CAPACITY = wdcc_pkg::CAPACITY_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wdcc_pkg::cfg_type  cfg,
   input  wire logic               take,
   input  wire wdcc_pkg::pix_type  pix,
   output wdcc_pkg::res_type       res
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + wdcc_pkg::LIMIT_W;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);

   logic [wdcc_pkg::COLOR_W-1:0] seen_ff [CAPACITY];
   logic [CNT_W-1:0]             used_ff, used_in;
   logic                         ovf_ff, ovf_in;
   logic [CAPACITY-1:0]          hit_vec;
   logic                         hit, full, insert;
   logic [CNT_W-1:0]             used_next;
   logic                         ovf_next;
   logic [CMP_W-1:0]             used_wide;

   // An entry only takes part once it lies below the fill count.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i] = (CNT_W'(i) < used_ff) && (seen_ff[i] == pix.color);
      end
   end

   assign hit    = |hit_vec;
   assign full   = (used_ff == FULL);
   assign insert = take && pix.in_rect && !hit && !full;

   always_comb begin
      used_next = used_ff;
      ovf_next  = ovf_ff;
      if (take && pix.in_rect && !hit) begin
         if (full) begin
            ovf_next = 1'b1;
         end else begin
            used_next = used_ff + CNT_W'(1);
         end
      end
      used_wide          = CMP_W'(used_next);
      res.distinct_count = used_wide[wdcc_pkg::COUNT_W-1:0];
      res.overflow       = ovf_next;
      res.few_colors     = cfg.compare_enable &&
                           (used_wide <= CMP_W'(cfg.color_limit));
      // Clear the store after the frame's last pixel.
      if (take && pix.last) begin
         used_in = '0;
         ovf_in  = 1'b0;
      end else begin
         used_in = used_next;
         ovf_in  = ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         used_ff <= used_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         seen_ff[used_ff[IDX_W-1:0]] <= pix.color;
      end
   end

endmodule
`default_nettype wire

/* tb/window_distinct_color_counter_tb.sv */
// Self-checking testbench for the window distinct color counter.
`timescale 1ns / 100ps
module window_distinct_color_counter_tb;

   localparam int STORE_DEPTH = wdcc_pkg::CAPACITY_DEFAULT;
   localparam int MAX_COORD   = 4095;

   // Tracks the distinct colors of the open frame and the frame results still owed.
   class frame_color_tally;
      wdcc_pkg::cfg_type     regs;
      logic [31:0]           seen[$];
      bit                    overflowed;
      wdcc_pkg::res_type     frame_results[$];
      int unsigned           errors;

      function new();
         regs = '0;
         overflowed = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic [wdcc_pkg::CSR_ADDR_W-1:0] idx,
                              logic [wdcc_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            wdcc_pkg::REG_X_START:        regs.x_start = val[wdcc_pkg::COORD_W-1:0];
            wdcc_pkg::REG_Y_START:        regs.y_start = val[wdcc_pkg::COORD_W-1:0];
            wdcc_pkg::REG_X_END:          regs.x_end = val[wdcc_pkg::BOUND_W-1:0];
            wdcc_pkg::REG_Y_END:          regs.y_end = val[wdcc_pkg::BOUND_W-1:0];
            wdcc_pkg::REG_COMPARE_ENABLE: regs.compare_enable = val[0];
            wdcc_pkg::REG_COLOR_LIMIT:    regs.color_limit = val[wdcc_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [wdcc_pkg::COORD_W-1:0] x,
                               logic [wdcc_pkg::COORD_W-1:0] y,
                               logic [wdcc_pkg::COLOR_W-1:0] color, logic last);
         bit                in_box;
         bit                hit;
         wdcc_pkg::res_type r;
         in_box = x >= regs.x_start && x < regs.x_end && y >= regs.y_start && y < regs.y_end;
         hit = 1'b0;
         if (in_box) begin
            foreach (seen[i]) if (seen[i] == color) hit = 1'b1;
            if (!hit) begin
               if (seen.size() < STORE_DEPTH) seen.push_back(color);
               else overflowed = 1'b1;
            end
         end
         if (last) begin
            r.distinct_count = wdcc_pkg::COUNT_W'(seen.size());
            r.overflow = overflowed;
            r.few_colors = regs.compare_enable && (seen.size() <= regs.color_limit);
            frame_results.push_back(r);
            seen.delete();
            overflowed = 1'b0;
         end
      endfunction

      function void check_field(string what, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [wdcc_pkg::RSP_W-1:0] word);
         wdcc_pkg::res_type want;
         if (frame_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, word);
            errors++;
            return;
         end
         want = frame_results.pop_front();
         check_field("distinct_count", int'(want.distinct_count),
                     int'(word[wdcc_pkg::COUNT_W-1:0]));
         check_field("overflow", int'(want.overflow), int'(word[wdcc_pkg::COUNT_W]));
         check_field("few_colors", int'(want.few_colors), int'(word[wdcc_pkg::COUNT_W+1]));
         check_field("padding", 0, int'(word[wdcc_pkg::RSP_W-1:wdcc_pkg::COUNT_W+2]));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [wdcc_pkg::REQ_W-1:0]      req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [wdcc_pkg::RSP_W-1:0]      rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [wdcc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [wdcc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   bit                              no_idle = 1'b0;

   frame_color_tally tally = new();

   window_distinct_color_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= no_idle || $urandom_range(99) >= 9;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tally.check_result(rsp_tdata);
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Write every register in index order; the caller is at a falling edge with the block idle.
   task automatic apply_config(input int xs, input int ys, input int xe, input int ye,
                               input int ce, input int lim);
      logic [wdcc_pkg::CSR_ADDR_W-1:0] idx [6];
      logic [wdcc_pkg::CSR_DATA_W-1:0] val [6];
      idx = '{wdcc_pkg::REG_X_START, wdcc_pkg::REG_Y_START, wdcc_pkg::REG_X_END,
              wdcc_pkg::REG_Y_END, wdcc_pkg::REG_COMPARE_ENABLE, wdcc_pkg::REG_COLOR_LIMIT};
      val = '{wdcc_pkg::CSR_DATA_W'(xs), wdcc_pkg::CSR_DATA_W'(ys),
              wdcc_pkg::CSR_DATA_W'(xe), wdcc_pkg::CSR_DATA_W'(ye),
              wdcc_pkg::CSR_DATA_W'(ce), wdcc_pkg::CSR_DATA_W'(lim)};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= val[i];
         tally.write_reg(idx[i], val[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [wdcc_pkg::COORD_W-1:0] x,
                             input logic [wdcc_pkg::COORD_W-1:0] y,
                             input logic [wdcc_pkg::COLOR_W-1:0] color, input logic last);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {color, y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tally.note_pixel(x, y, color, last);
      @(negedge clock);
   endtask

   // Drop valid, drain owed results, then cover the pipeline of a pixel without a result.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tally.frame_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly pick within the rectangle or one past its edges, sometimes anywhere in the frame.
   function automatic logic [wdcc_pkg::COORD_W-1:0] pick_coord(int lo, int hi);
      int a, b;
      a = lo > 0 ? lo - 1 : 0;
      b = hi > MAX_COORD ? MAX_COORD : hi;
      if ($urandom_range(3) == 0 || a > b) return wdcc_pkg::COORD_W'($urandom_range(MAX_COORD));
      return wdcc_pkg::COORD_W'($urandom_range(b, a));
   endfunction

   task automatic send_frame(input int len, input int palette_size, input bit flood,
                             input bit close);
      logic [wdcc_pkg::COLOR_W-1:0] palette[$];
      logic [wdcc_pkg::COLOR_W-1:0] color;
      logic [wdcc_pkg::COORD_W-1:0] x, y;
      for (int i = 0; i < palette_size; i++) palette.push_back($urandom);
      for (int i = 0; i < len; i++) begin
         color = flood ? $urandom : palette[$urandom_range(palette_size - 1)];
         x = pick_coord(tally.regs.x_start, tally.regs.x_end);
         y = pick_coord(tally.regs.y_start, tally.regs.y_end);
         send_pixel(x, y, color, close && i == len - 1);
      end
   endtask

   initial begin
      int sent, phase, nframes, len, kind, palette_size, lim;
      int xs, ys, xe, ye;
      bit flood, close;
      sent = 0;
      phase = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // whole frame, field extremes, duplicate color
      apply_config(0, 0, 4096, 4096, 1, 63);
      send_pixel(12'h000, 12'h000, 32'h0000_0000, 1'b0);
      send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0);
      send_pixel(12'hFFF, 12'h000, 32'hFFFF_FFFF, 1'b0);
      send_pixel(12'h000, 12'hFFF, 32'hA5A5_A5A5, 1'b1);
      send_pixel(12'h555, 12'hAAA, 32'h5A5A_5A5A, 1'b1);
      settle();

      // empty rectangle reports zero
      apply_config(100, 200, 100, 300, 1, 0);
      send_pixel(12'd100, 12'd250, 32'h1111_1111, 1'b0);
      send_pixel(12'd150, 12'd250, 32'h2222_2222, 1'b1);
      settle();

      // rectangle bounds, last mark on an outside pixel
      apply_config(10, 10, 20, 20, 1, 2);
      send_pixel(12'd9, 12'd15, 32'h0000_0001, 1'b0);
      send_pixel(12'd10, 12'd15, 32'h0000_0001, 1'b0);
      send_pixel(12'd19, 12'd10, 32'h0000_0002, 1'b0);
      send_pixel(12'd20, 12'd15, 32'h0000_0003, 1'b0);
      send_pixel(12'd15, 12'd9, 32'h0000_0004, 1'b0);
      send_pixel(12'd15, 12'd19, 32'h0000_0005, 1'b0);
      send_pixel(12'd15, 12'd20, 32'h0000_0006, 1'b1);
      send_pixel(12'd15, 12'd15, 32'h0000_0001, 1'b1);
      // leave a frame open across a register update
      send_pixel(12'd12, 12'd12, 32'h0000_0007, 1'b0);
      settle();
      apply_config(10, 10, 20, 20, 0, 2);
      send_pixel(12'd13, 12'd13, 32'h0000_0008, 1'b1);
      settle();

      while (sent < 900) begin
         no_idle <= (phase == 4 || phase == 5);
         kind = $urandom_range(4);
         case (kind)
            0: begin
               xs = 0; ys = 0; xe = 4096; ye = 4096;
            end
            1: begin
               xs = $urandom_range(MAX_COORD);
               ys = $urandom_range(MAX_COORD);
               xe = xs + $urandom_range(64, 1);
               ye = ys + $urandom_range(64, 1);
               if (xe > 4096) xe = 4096;
               if (ye > 4096) ye = 4096;
            end
            2: begin
               xs = $urandom_range(MAX_COORD);
               ys = $urandom_range(MAX_COORD);
               xe = $urandom_range(xs);
               ye = ys + $urandom_range(20);
            end
            3: begin
               xs = MAX_COORD; ys = MAX_COORD; xe = 4096; ye = 4096;
            end
            default: begin
               xs = $urandom_range(MAX_COORD);
               ys = $urandom_range(MAX_COORD);
               xe = $urandom_range(4096);
               ye = $urandom_range(4096);
            end
         endcase
         lim = ($urandom_range(2) == 0) ? ($urandom_range(1) ? 63 : 0) : $urandom_range(63);
         apply_config(xs, ys, xe, ye, $urandom_range(1), lim);
         nframes = $urandom_range(4, 1);
         for (int f = 0; f < nframes; f++) begin
            // flood the store past capacity only when every pixel is inside
            flood = kind == 0 && $urandom_range(3) == 0;
            len = flood ? $urandom_range(110, 66) : $urandom_range(30, 1);
            palette_size = $urandom_range(4) == 0 ? 40 : $urandom_range(12, 1);
            close = !(f == nframes - 1 && $urandom_range(7) == 0);
            send_frame(len, palette_size, flood, close);
            sent += len;
         end
         settle();
         phase++;
      end

      if (tally.errors == 0 && tally.frame_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
